FILE: hdl/prrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prrs_pkg
// Types and constants shared by the priority round-robin scheduler.
// ----------------------------------------------------------------------------
package prrs_pkg;

  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned QUANT_W = 16;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd10;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    CMD_ADD      = 1'b0,
    CMD_DISPATCH = 1'b1
  } cmd_e;

  // Input item as seen on the ports
  typedef struct packed {
    logic               action;
    logic [PRIO_W-1:0]  task_priority;
    logic [BURST_W-1:0] task_burst;
  } task_in_t;

  // Result item as seen on the ports
  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    task_id;
    logic [BURST_W-1:0] slice_length;
    logic               task_finished;
  } result_t;

  // Classified command held in the queue
  typedef struct packed {
    cmd_e               kind;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } cmd_t;

  // Queue head offered to the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  // One table entry as stored in RAM
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] remaining;
    logic [ID_W-1:0]    id;
  } entry_t;

endpackage
`default_nettype wire

FILE: hdl/prrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hdl/prrs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prrs_front
// Accepts items, classifies them as add or dispatch, queues two deep.
// ----------------------------------------------------------------------------
module prrs_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire prrs_pkg::task_in_t item_i,
  output prrs_pkg::qhead_t       head_o,
  input  wire logic              pop_i
);
  import prrs_pkg::*;

  cmd_t       fifo_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd_in;

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;

  always_comb begin
    cmd_in.kind  = item_i.action ? CMD_DISPATCH : CMD_ADD;
    cmd_in.prio  = item_i.task_priority;
    cmd_in.burst = item_i.task_burst;
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = fifo_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/prrs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prrs_back
// Executes queued commands against the task table, one slot per cycle.
// ----------------------------------------------------------------------------
module prrs_back #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire prrs_pkg::qhead_t        head_i,
  output logic                         pop_o,
  input  wire logic [prrs_pkg::QUANT_W-1:0] quantum_i,
  output logic                         done_o,
  output prrs_pkg::result_t            result_o
);
  import prrs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam logic [IW-1:0] LastSlot = IW'(MAX_TASKS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ADD   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [IW-1:0]          cnt_q, cnt_d;
  logic [IW-1:0]          slot_q, slot_d;
  logic [MAX_TASKS-1:0]   valid_q, valid_d;
  logic [ID_W-1:0]        next_id_q, next_id_d;
  logic [IW-1:0]          last_q, last_d;
  logic                   any_q, any_d;
  entry_t                 best_q, best_d;
  logic [IW-1:0]          bslot_q, bslot_d;
  logic                   rd_live_q, rd_vld_q;
  logic [IW-1:0]          rd_slot_q;
  logic [PRIO_W-1:0]      add_prio_q, add_prio_d;
  logic [BURST_W-1:0]     add_burst_q, add_burst_d;
  logic                   done_q, done_d;
  result_t                res_q, res_d;

  logic                   we;
  logic [IW-1:0]          waddr;
  entry_t                 wdata;
  entry_t                 rdata;

  logic [QUANT_W-1:0]     quant;
  logic [BURST_W-1:0]     slice;
  logic [BURST_W-1:0]     new_rem;

  prrs_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  function automatic logic [IW-1:0] step_slot(input logic [IW-1:0] s);
    step_slot = (s == LastSlot) ? '0 : s + IW'(1);
  endfunction

  // slice = min(remaining, quantum), quantum of zero counts as one
  always_comb begin
    quant   = (quantum_i == '0) ? QUANT_W'(1) : quantum_i;
    slice   = (best_q.remaining > quant) ? quant : best_q.remaining;
    new_rem = best_q.remaining - slice;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    valid_d     = valid_q;
    next_id_d   = next_id_q;
    last_d      = last_q;
    any_d       = any_q;
    best_d      = best_q;
    bslot_d     = bslot_q;
    add_prio_d  = add_prio_q;
    add_burst_d = add_burst_q;
    done_d      = 1'b0;
    res_d       = '0;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;

    // Compare each returned entry; the scan runs in cyclic order from the
    // slot after the last served one, so the first strict maximum wins ties.
    if (rd_live_q && rd_vld_q && (!any_q || (rdata.prio > best_q.prio))) begin
      any_d   = 1'b1;
      best_d  = rdata;
      bslot_d = rd_slot_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cnt_d = '0;
          if (head_i.cmd.kind == CMD_ADD) begin
            add_prio_d  = head_i.cmd.prio;
            add_burst_d = head_i.cmd.burst;
            state_d     = S_ADD;
          end else begin
            slot_d  = step_slot(last_q);
            any_d   = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_ADD: begin
        if (!valid_q[cnt_q]) begin
          we                = 1'b1;
          waddr             = cnt_q;
          wdata.prio        = add_prio_q;
          wdata.remaining   = add_burst_q;
          wdata.id          = next_id_q;
          valid_d[cnt_q]    = 1'b1;
          done_d            = 1'b1;
          res_d.status      = ST_OK;
          res_d.task_id     = next_id_q;
          next_id_d         = next_id_q + ID_W'(1);
          state_d           = S_IDLE;
        end else if (cnt_q == LastSlot) begin
          done_d       = 1'b1;
          res_d.status = ST_FULL;
          state_d      = S_IDLE;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      S_SCAN: begin
        slot_d = step_slot(slot_q);
        if (cnt_q == LastSlot) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (!any_q) begin
          res_d.status = ST_EMPTY;
        end else begin
          we                  = 1'b1;
          waddr               = bslot_q;
          wdata.prio          = best_q.prio;
          wdata.remaining     = new_rem;
          wdata.id            = best_q.id;
          last_d              = bslot_q;
          if (new_rem == '0) begin
            valid_d[bslot_q] = 1'b0;
          end
          res_d.status        = ST_OK;
          res_d.task_id       = best_q.id;
          res_d.slice_length  = slice;
          res_d.task_finished = (new_rem == '0);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    bslot_q     <= bslot_d;
    slot_q      <= slot_d;
    rd_slot_q   <= slot_q;
    rd_vld_q    <= valid_q[slot_q];
    add_prio_q  <= add_prio_d;
    add_burst_q <= add_burst_d;
    res_q       <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      valid_q   <= '0;
      next_id_q <= '0;
      last_q    <= '0;
      any_q     <= 1'b0;
      rd_live_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      valid_q   <= valid_d;
      next_id_q <= next_id_d;
      last_q    <= last_d;
      any_q     <= any_d;
      rd_live_q <= (state_q == S_SCAN);
      done_q    <= done_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/priority_round_robin_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler
// Task table with highest-priority dispatch and round robin among equals.
// ----------------------------------------------------------------------------
// Drive an item with start while busy is low; every item gives exactly one
// result, shown on result_o for one cycle with done_o high, and the receiver
// must take it then. An add walks the valid bits from slot 0 one slot per
// cycle and answers once it finds a free slot or has checked the last one;
// a dispatch walks the whole table in cyclic order through the single read
// port of the table RAM, one slot per cycle, then answers with the task it
// picked or with an empty status. The front end holds up to two items, so
// busy rises only when two items wait behind the one in progress. Write the
// quantum only while no item is outstanding; a quantum of 0 acts as 1.
//
// Structure:
//   prrs_front : accepts and classifies items into a two-entry queue
//   prrs_back  : sequencer that searches the table and updates entries
//   prrs_ram   : entry store (priority, remaining burst, task id)
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire prrs_pkg::task_in_t            item_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [prrs_pkg::QUANT_W-1:0]  cfg_wdata_i,
  output logic                               done_o,
  output prrs_pkg::result_t                  result_o
);
  import prrs_pkg::*;

  qhead_t             head;
  logic               pop;
  logic [QUANT_W-1:0] quantum_q;

  // Time quantum register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else if (cfg_we_i) begin
      quantum_q <= cfg_wdata_i;
    end
  end

  prrs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .head_o (head),
    .pop_i  (pop)
  );

  prrs_back #(
    .MAX_TASKS (MAX_TASKS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .quantum_i (quantum_q),
    .done_o    (done_o),
    .result_o  (result_o)
  );

endmodule
`default_nettype wire

FILE: dv/priority_round_robin_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_test
// Self-checking bench for the priority round-robin task scheduler.
// ----------------------------------------------------------------------------
// A short directed part covers the empty table, the first pick after reset,
// zero and full-range bursts, the extreme priorities, a full table and the
// quantum extremes. Random phases then mix adds and dispatches under a new
// quantum each. Each phase ends by emptying the table. Every result is
// checked against an in-bench model of the task table.
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler_test;
  import prrs_pkg::*;

  localparam int unsigned SLOTS         = 16;
  localparam int unsigned ANSWER_CYCLES = SLOTS + 4;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 200;
  localparam int unsigned PRINT_CAP     = 50;
  localparam int unsigned IN_W          = $bits(task_in_t);

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  task_in_t           item_i;
  logic               cfg_we_i;
  logic [QUANT_W-1:0] cfg_wdata_i;
  logic               done_o;
  result_t            result_o;

  priority_round_robin_scheduler #(
    .MAX_TASKS(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always #2 clk_i = ~clk_i;

  // Bench copy of the task table and scheduler state
  logic               slot_valid [SLOTS];
  logic [PRIO_W-1:0]  slot_prio  [SLOTS];
  logic [BURST_W-1:0] slot_left  [SLOTS];
  logic [ID_W-1:0]    slot_id    [SLOTS];
  logic [ID_W-1:0]    id_next;
  int unsigned        served_slot;
  logic [QUANT_W-1:0] quantum;

  // Results predicted for accepted items, oldest first
  result_t            pending_results[$];

  int unsigned mismatches;
  int unsigned n_add, n_full, n_dispatch, n_empty, n_finished, n_cfg, n_checked;

  // Applies one item to the bench table and returns the result it must give.
  function automatic result_t sched_step(input task_in_t it);
    result_t            r;
    logic [PRIO_W-1:0]  top;
    logic [BURST_W-1:0] q;
    logic [BURST_W-1:0] cut;
    bit                 found;
    int unsigned        pick;
    int unsigned        s;
    r.status        = ST_OK;
    r.task_id       = '0;
    r.slice_length  = '0;
    r.task_finished = 1'b0;
    found = 1'b0;
    top   = '0;
    pick  = 0;
    if (cmd_e'(it.action) == CMD_ADD) begin
      // lowest free slot takes the task
      for (int k = 0; k < SLOTS; k++) begin
        if (!found && !slot_valid[k]) begin
          found         = 1'b1;
          slot_valid[k] = 1'b1;
          slot_prio[k]  = it.task_priority;
          slot_left[k]  = it.task_burst;
          slot_id[k]    = id_next;
        end
      end
      if (found) begin
        r.task_id = id_next;
        id_next   = id_next + 1'b1;   // wraps at 256
        n_add++;
      end else begin
        r.status = ST_FULL;
        n_full++;
      end
    end else begin
      for (int k = 0; k < SLOTS; k++) begin
        if (slot_valid[k] && (!found || slot_prio[k] > top)) begin
          top   = slot_prio[k];
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        // round robin among equals: first match after the last served slot
        found = 1'b0;
        for (int k = 1; k <= SLOTS; k++) begin
          s = (served_slot + k) % SLOTS;
          if (!found && slot_valid[s] && slot_prio[s] == top) begin
            pick  = s;
            found = 1'b1;
          end
        end
        q   = (quantum == '0) ? BURST_W'(1) : quantum;
        cut = (slot_left[pick] > q) ? q : slot_left[pick];
        slot_left[pick] = slot_left[pick] - cut;
        served_slot     = pick;
        r.task_id       = slot_id[pick];
        r.slice_length  = cut;
        if (slot_left[pick] == '0) begin
          slot_valid[pick] = 1'b0;
          r.task_finished  = 1'b1;
          n_finished++;
        end
        n_dispatch++;
      end
    end
    return r;
  endfunction

  function automatic int unsigned slots_used();
    int unsigned n;
    n = 0;
    for (int k = 0; k < SLOTS; k++) n += slot_valid[k];
    return n;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t ns  mismatch: %s", $realtime, what);
  endtask

  // Result checker: done_o marks a result for one cycle, taken at the edge.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (result_o.status !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d",
                                  result_o.status, want.status));
        if (result_o.task_id !== want.task_id)
          flag_mismatch($sformatf("task_id got %0d want %0d",
                                  result_o.task_id, want.task_id));
        if (result_o.slice_length !== want.slice_length)
          flag_mismatch($sformatf("slice_length got %0d want %0d",
                                  result_o.slice_length, want.slice_length));
        if (result_o.task_finished !== want.task_finished)
          flag_mismatch($sformatf("task_finished got %0d want %0d",
                                  result_o.task_finished, want.task_finished));
      end
    end
  end

  // Holds start high until the block takes the item. Start is left high so
  // a following item goes out back to back.
  task automatic send_item(input task_in_t it);
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(sched_step(it));
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      start  <= 1'b0;
      item_i <= task_in_t'(IN_W'($urandom));   // noise the block must ignore
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned random_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (ANSWER_CYCLES) @(posedge clk_i);
  endtask

  // Quantum is only written with nothing in flight.
  task automatic write_quantum(input logic [QUANT_W-1:0] value);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    quantum = value;
    n_cfg++;
  endtask

  function automatic task_in_t add_item(input logic [PRIO_W-1:0]  p,
                                        input logic [BURST_W-1:0] b);
    task_in_t it;
    it.action        = CMD_ADD;
    it.task_priority = p;
    it.task_burst    = b;
    return it;
  endfunction

  // priority and burst are don't-care on a dispatch; keep them random
  function automatic task_in_t dispatch_item();
    task_in_t it;
    it               = task_in_t'(IN_W'($urandom));
    it.action        = CMD_DISPATCH;
    return it;
  endfunction

  // Few priority levels so equals rotate often; a share of full-range values.
  function automatic task_in_t random_item(input int unsigned add_pct);
    logic [PRIO_W-1:0]  p;
    logic [BURST_W-1:0] b;
    int unsigned        roll;
    if ($urandom_range(0, 99) >= add_pct) return dispatch_item();
    roll = $urandom_range(0, 99);
    if (roll < 60)      p = PRIO_W'($urandom_range(0, 3));
    else if (roll < 80) p = roll[0] ? 8'hFF : 8'h00;
    else                p = PRIO_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 70)      b = BURST_W'($urandom_range(0, 32));
    else if (roll < 90) b = BURST_W'($urandom_range(0, 255));
    else                b = BURST_W'($urandom);
    return add_item(p, b);
  endfunction

  // Empty table, first pick after reset, zero and maximum burst.
  task automatic test_empty_and_first_pick();
    send_item(dispatch_item());                  // nothing to run
    send_item(add_item(8'hFF, 16'hFFFF));        // slot 0
    send_item(add_item(8'hFF, 16'h0000));        // slot 1, zero burst
    send_item(add_item(8'h00, 16'h0001));        // slot 2, lowest priority
    // search starts after slot 0, so slot 1 goes first and ends at once
    send_item(dispatch_item());
    send_item(dispatch_item());                  // slot 0 gets the reset quantum
  endtask

  // 14 slots are free at this point: fill them, then one add is rejected.
  task automatic test_table_full();
    for (int k = 0; k < 15; k++) begin
      send_item(add_item(PRIO_W'($urandom_range(1, 254)),
                         BURST_W'($urandom_range(1, 20))));
    end
    // sender holds off until every answer is in
    wait_results_drained();
  endtask

  // Maximum quantum finishes the long task; zero quantum acts as one.
  task automatic test_quantum_extremes();
    write_quantum(16'hFFFF);
    send_item(dispatch_item());
    write_quantum(16'h0000);
    send_item(dispatch_item());
  endtask

  // Random phases, each with its quantum; the add rate alternates. Some
  // phases run with no sender gaps at all. Each ends by running the table
  // dry under the largest quantum so the next one starts from empty.
  task automatic test_random_mix();
    logic [QUANT_W-1:0] q_plan [PHASES];
    int unsigned        add_pct;
    bit                 no_gaps;
    q_plan = '{16'd1, 16'hFFFF, 16'd0, QUANTUM_RESET, 16'd3,
               QUANT_W'($urandom_range(1, 300)), 16'd2,
               QUANT_W'($urandom_range(1, 300))};
    for (int ph = 0; ph < PHASES; ph++) begin
      write_quantum(q_plan[ph]);
      add_pct = (ph % 2 == 1) ? 65 : 40;
      no_gaps = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item(add_pct));
        if (!no_gaps) pause_sender(random_gap());
        if ($urandom_range(0, 199) == 0) wait_results_drained();
      end
      write_quantum(16'hFFFF);
      while (slots_used() != 0) begin
        send_item(dispatch_item());
        pause_sender(random_gap());
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    for (int k = 0; k < SLOTS; k++) begin
      slot_valid[k] = 1'b0;
      slot_prio[k]  = '0;
      slot_left[k]  = '0;
      slot_id[k]    = '0;
    end
    id_next     = '0;
    served_slot = 0;
    quantum     = QUANTUM_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_first_pick();
    test_table_full();
    test_quantum_extremes();
    test_random_mix();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // stray results after the last answer still get flagged here
    repeat (2 * ANSWER_CYCLES) @(posedge clk_i);

    $display("run: %0d adds, %0d adds on a full table, %0d dispatches, %0d on an empty table",
             n_add, n_full, n_dispatch, n_empty);
    $display("run: %0d tasks completed, %0d quantum writes, %0d results checked",
             n_finished, n_cfg, n_checked);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
